[hw/rtl/prefix_suffix_palindrome_macros.svh]
// assertion macros for the prefix/suffix palindrome block
// expects i_clk in the scope of every use, and i_rst_n too where PSP_ASSERT is used
`ifndef PREFIX_SUFFIX_PALINDROME_MACROS_SVH
`define PREFIX_SUFFIX_PALINDROME_MACROS_SVH

// checked only out of reset
`define PSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define PSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hw/rtl/psp_pkg.sv]
// shared constants and controller/datapath command and status types
// for the prefix/suffix palindrome block; no dependencies
package psp_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int BT_DEPTH  = 2 * MAX_LEN + 2;
    localparam int BT_W      = $clog2(BT_DEPTH);
    localparam int OUTER_W   = 10;
    localparam int MIDDLE_W  = 11;

    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [BT_W-1:0]        t_bidx;
    typedef logic signed [BT_W-1:0] t_border;

    typedef struct packed {
        logic load;
        logic chk;
        logic scan_rd;
        logic scan_ev;
        logic kmp_init;
        logic kmp_rev;
        logic kmp_rd;
        logic kmp_ev;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic ovf;
        logic scan_more;
        logic mid_empty;
        logic kmp_done;
        logic kmp_rev;
    } t_stat;

endpackage

[hw/rtl/psp_dp.sv]
// datapath: text store, border table, scan and failure-function registers,
// result register; uses psp_pkg and the assertion macro header
`include "prefix_suffix_palindrome_macros.svh"

module psp_dp
    import psp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [7:0]          i_symbol,
    output logic [OUTER_W-1:0]  o_outer_len,
    output logic [MIDDLE_W-1:0] o_middle_len,
    output logic                o_middle_from_end,
    output logic                o_overflow
);

    logic [7:0] r_text [MAX_LEN];
    t_bidx      r_bt   [BT_DEPTH];

    t_cnt    r_cnt;
    logic    r_ovf;
    t_addr   r_pre;
    t_bidx   r_cur;
    t_border r_k;
    logic    r_rev;
    t_cnt    r_b_pre;
    t_cnt    r_b_suf;
    logic [7:0] r_rd_a;
    logic [7:0] r_rd_b;
    t_bidx   r_bt_rd;

    t_cnt    w_m;
    t_bidx   w_len;
    t_addr   w_addr_a;
    t_addr   w_addr_b;
    logic    w_room;
    logic    w_scan_more;
    logic    w_k_neg;
    t_bidx   w_k_u;
    logic    w_cur_sep;
    logic    w_k_sep;
    logic    w_match;
    t_bidx   w_cur_inc;
    t_border w_k_inc;
    logic    w_kmp_done;
    logic    w_fin;
    logic signed [BT_W:0] w_cur_s;
    logic signed [BT_W:0] w_m_s;

    // text address of position i of the joined sequence
    function automatic t_addr joined_addr(t_addr base, t_cnt m, t_bidx i, logic rev);
        t_bidx mm;
        t_bidx pos;
        mm = BT_W'(m);
        if (i < mm) begin
            pos = rev ? (mm - BT_W'(1) - i) : i;
        end else begin
            pos = rev ? (i - mm - BT_W'(1)) : ((mm << 1) - i);
        end
        return ADDR_W'(BT_W'(base) + pos);
    endfunction

    assign w_room = (r_cnt < CNT_W'(MAX_LEN));
    assign w_m    = r_cnt - (CNT_W'(r_pre) << 1);
    assign w_len  = (BT_W'(w_m) << 1) | BT_W'(1);

    always_comb begin
        if (i_cmd.kmp_rd) begin
            w_addr_a = joined_addr(r_pre, w_m, r_cur, r_rev);
            w_addr_b = joined_addr(r_pre, w_m, w_k_u, r_rev);
        end else begin
            w_addr_a = r_pre;
            w_addr_b = ADDR_W'(r_cnt - CNT_W'(1) - CNT_W'(r_pre));
        end
    end

    assign w_scan_more = (CNT_W'(r_pre) < (r_cnt >> 1)) && (r_rd_a == r_rd_b);

    // separator sits at position m and matches only itself
    assign w_k_neg    = r_k[BT_W-1];
    assign w_k_u      = t_bidx'(r_k);
    assign w_cur_sep  = (r_cur == BT_W'(w_m));
    assign w_k_sep    = (w_k_u == BT_W'(w_m));
    assign w_match    = w_k_neg ||
                        ((w_cur_sep == w_k_sep) && (w_cur_sep || (r_rd_a == r_rd_b)));
    assign w_cur_inc  = r_cur + BT_W'(1);
    assign w_k_inc    = r_k + t_border'(1);
    assign w_kmp_done = w_match && (w_cur_inc == w_len);
    assign w_fin      = i_cmd.kmp_ev && w_kmp_done;
    assign w_cur_s    = $signed({1'b0, r_cur});
    assign w_m_s      = $signed({1'b0, BT_W'(w_m)});

    assign o_stat.ovf       = r_ovf;
    assign o_stat.scan_more = w_scan_more;
    assign o_stat.mid_empty = (w_m == '0);
    assign o_stat.kmp_done  = w_kmp_done;
    assign o_stat.kmp_rev   = r_rev;

    // text store: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            r_text[r_cnt[ADDR_W-1:0]] <= i_symbol;
        end
        if (i_cmd.scan_rd || i_cmd.kmp_rd) begin
            r_rd_a <= r_text[w_addr_a];
            r_rd_b <= r_text[w_addr_b];
        end
    end

    // border table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.kmp_ev && w_match) begin
            r_bt[w_cur_inc] <= t_bidx'(w_k_inc);
        end
        if (i_cmd.kmp_rd) begin
            r_bt_rd <= r_bt[w_k_u];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_room) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk) begin
            r_pre <= '0;
        end else if (i_cmd.scan_ev && w_scan_more) begin
            r_pre <= r_pre + ADDR_W'(1);
        end
        // end of a pass: keep its final border
        if (w_fin) begin
            if (r_rev) begin
                r_b_suf <= CNT_W'(t_bidx'(w_k_inc));
            end else begin
                r_b_pre <= CNT_W'(t_bidx'(w_k_inc));
            end
        end
        // a new pass restarts position and border
        if (i_cmd.kmp_init) begin
            r_cur <= '0;
            r_k   <= '1;
            r_rev <= i_cmd.kmp_rev;
        end else if (i_cmd.kmp_ev) begin
            if (w_match) begin
                r_cur <= w_cur_inc;
                r_k   <= w_k_inc;
            end else if (r_k == '0) begin
                r_k <= '1;
            end else begin
                r_k <= t_border'(r_bt_rd);
            end
        end
        if (i_cmd.out_load) begin
            if (r_ovf) begin
                o_outer_len       <= '0;
                o_middle_len      <= '0;
                o_middle_from_end <= 1'b0;
                o_overflow        <= 1'b1;
            end else begin
                o_outer_len <= OUTER_W'(r_pre);
                o_overflow  <= 1'b0;
                if (w_m == '0) begin
                    o_middle_len      <= '0;
                    o_middle_from_end <= 1'b0;
                end else if (r_b_suf > r_b_pre) begin
                    o_middle_len      <= MIDDLE_W'(r_b_suf);
                    o_middle_from_end <= 1'b1;
                end else begin
                    o_middle_len      <= MIDDLE_W'(r_b_pre);
                    o_middle_from_end <= 1'b0;
                end
            end
        end
    end

    `PSP_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(MAX_LEN), "load count beyond buffer")
    `PSP_ASSERT(a_k_below_cur, i_cmd.kmp_ev |-> (r_k < w_cur_s), "border not below position")
    `PSP_ASSERT(a_border_le_mid, w_fin |-> (w_k_inc <= w_m_s), "final border exceeds middle")

endmodule

[hw/rtl/psp_ctrl.sv]
// controller: sequences load, outer scan, two failure-function passes
// and result hand-off; uses psp_pkg and the assertion macro header
`include "prefix_suffix_palindrome_macros.svh"

module psp_ctrl
    import psp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_is_last,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_EV,
        S_KMP_RD,
        S_KMP_EV,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   n_out_valid;
    logic   w_in_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = o_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    o_cmd.load = 1'b1;
                    if (i_is_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_stat.ovf ? S_OUT : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                o_cmd.scan_ev = 1'b1;
                if (i_stat.scan_more) begin
                    n_state = S_SCAN_RD;
                end else if (i_stat.mid_empty) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.kmp_init = 1'b1;
                    o_cmd.kmp_rev  = 1'b0;
                    n_state        = S_KMP_RD;
                end
            end
            S_KMP_RD: begin
                o_cmd.kmp_rd = 1'b1;
                n_state      = S_KMP_EV;
            end
            S_KMP_EV: begin
                o_cmd.kmp_ev = 1'b1;
                n_state      = S_KMP_RD;
                if (i_stat.kmp_done) begin
                    if (i_stat.kmp_rev) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd.kmp_init = 1'b1;
                        o_cmd.kmp_rev  = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!o_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            o_out_valid <= n_out_valid;
        end
    end

    `PSP_ASSERT(a_out_free, o_cmd.out_load |-> (!o_out_valid || i_out_ready), "result register overwritten")
    `PSP_ASSERT(a_one_cmd, $onehot0({o_cmd.load, o_cmd.chk, o_cmd.scan_rd, o_cmd.scan_ev, o_cmd.kmp_rd, o_cmd.kmp_ev, o_cmd.out_load}), "overlapping commands")
    `PSP_ASSERT(a_last_blocks, (w_in_acc && i_is_last) |=> !o_in_ready, "input open while string is processed")
    `PSP_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

[hw/rtl/prefix_suffix_palindrome.sv]
// top level of the prefix/suffix palindrome block
// depends on psp_pkg, psp_ctrl and psp_dp

// A string enters one byte per request, the final byte flagged by
// i_is_last; each byte takes one cycle while the block is loading. After
// the final byte the block computes, from a 1024-byte text store and a
// 2050-entry border table, the longest outer part whose ends mirror each
// other and then the longest palindromic prefix or suffix of what remains,
// and hands out one result request. Every step of the outer scan and of
// both failure-function passes is a read of the registered-read memories
// followed by a compare; the passes run only when the middle is non-empty,
// and their length depends on how often the failure function falls back.
// An overflowed string goes from the check straight to the result. The
// result is loaded only once the previous one has been taken. No byte is
// taken while a string is processed or its result waits to be loaded. A
// result waits in its own register, so loading of the next string may
// start before it is taken. A string longer than 1024 bytes returns
// overflow with the other fields zero. The memories need no clearing
// after reset.
module prefix_suffix_palindrome
    import psp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte requests
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_symbol,
    input  logic                i_is_last,
    // result requests
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OUTER_W-1:0]  o_outer_len,
    output logic [MIDDLE_W-1:0] o_middle_len,
    output logic                o_middle_from_end,
    output logic                o_overflow
);

    // commands from the sequencer, status back from the datapath
    t_cmd  w_cmd;
    t_stat w_stat;

    psp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_is_last   (i_is_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // memories, scan and border registers, result register
    psp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_symbol          (i_symbol),
        .o_outer_len       (o_outer_len),
        .o_middle_len      (o_middle_len),
        .o_middle_from_end (o_middle_from_end),
        .o_overflow        (o_overflow)
    );

endmodule

[verif/tb_top.sv]
// self-checking testbench for prefix_suffix_palindrome
// depends on psp_pkg and the prefix_suffix_palindrome rtl; nothing else
`timescale 1ns / 100ps

module tb_top;
    import psp_pkg::*;

    // one byte request as the driver sends it; hold_off makes the sender wait
    // until every outstanding result has come back before this byte goes out
    typedef struct {
        logic [7:0] sym;
        logic       last;
        bit         hold_off;
    } t_byte_req;

    // one result request as the block should return it
    typedef struct {
        logic [OUTER_W-1:0]  outer_len;
        logic [MIDDLE_W-1:0] middle_len;
        logic                from_end;
        logic                overflow;
    } t_split_result;

    localparam int SEP_CODE = 256;   // joining symbol, outside the byte range

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [7:0]          i_symbol = 8'h00;
    logic                i_is_last = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [OUTER_W-1:0]  o_outer_len;
    logic [MIDDLE_W-1:0] o_middle_len;
    logic                o_middle_from_end;
    logic                o_overflow;

    prefix_suffix_palindrome u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_symbol          (i_symbol),
        .i_is_last         (i_is_last),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_outer_len       (o_outer_len),
        .o_middle_len      (o_middle_len),
        .o_middle_from_end (o_middle_from_end),
        .o_overflow        (o_overflow)
    );

    always #1 i_clk = ~i_clk;

    t_byte_req     byte_queue[$];     // byte requests still to be sent
    t_split_result result_queue[$];   // results predicted but not yet returned
    logic [7:0]    word_q[$];         // string under construction

    // own copy of the block state
    logic [7:0] text_buf [0:MAX_LEN-1];
    int         fill_cnt = 0;
    bit         ovf_seen = 1'b0;
    int         joined [0:2*MAX_LEN];
    int         border [0:2*MAX_LEN];

    logic [7:0] alpha_syms [0:2];
    logic       in_fire = 1'b0;
    int         in_gap = 0;
    int         out_gap = 0;
    int         errors = 0;
    int         n_strings = 0;
    int         n_bytes = 0;
    int         n_ovf = 0;
    int         n_suffix = 0;
    int         longest = 0;
    int         small_items = 0;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // border length at the end of middle+sep+reverse(middle), or of
    // reverse(middle)+sep+middle when rev_first is set; the middle starts
    // at base and is m bytes long
    function automatic int border_at_end(int base, int m, bit rev_first);
        int len, i, k, pos;
        len = 2 * m + 1;
        for (i = 0; i < len; i++) begin
            if (i == m) begin
                joined[i] = SEP_CODE;
            end else begin
                if (i < m) pos = rev_first ? (m - 1 - i) : i;
                else       pos = rev_first ? (i - m - 1) : (2 * m - i);
                joined[i] = int'(text_buf[base + pos]);
            end
        end
        border[0] = 0;
        for (i = 1; i < len; i++) begin
            k = border[i-1];
            while (k > 0 && joined[i] != joined[k]) k = border[k-1];
            if (joined[i] == joined[k]) k++;
            border[i] = k;
        end
        return border[len-1];
    endfunction

    // takes one accepted byte; on the final byte works out the result
    task automatic palindrome_split(input logic [7:0] sym, input logic last);
        t_split_result r;
        int pre, m, b_pre, b_suf;
        if (fill_cnt < MAX_LEN) begin
            text_buf[fill_cnt] = sym;
            fill_cnt++;
        end else begin
            ovf_seen = 1'b1;
        end
        n_bytes++;
        if (!last) return;
        r = '{outer_len: '0, middle_len: '0, from_end: 1'b0, overflow: 1'b0};
        if (ovf_seen) begin
            r.overflow = 1'b1;
            n_ovf++;
        end else begin
            if (fill_cnt > longest) longest = fill_cnt;
            // strip the mirrored outer ends first
            pre = 0;
            while (pre < fill_cnt / 2 && text_buf[pre] == text_buf[fill_cnt - 1 - pre])
                pre++;
            m = fill_cnt - 2 * pre;
            r.outer_len = pre[OUTER_W-1:0];
            if (m > 0) begin
                b_pre = border_at_end(pre, m, 1'b0);
                b_suf = border_at_end(pre, m, 1'b1);
                // a tie goes to the prefix
                if (b_suf > b_pre) begin
                    r.middle_len = b_suf[MIDDLE_W-1:0];
                    r.from_end   = 1'b1;
                    n_suffix++;
                end else begin
                    r.middle_len = b_pre[MIDDLE_W-1:0];
                end
            end
        end
        result_queue.push_back(r);
        n_strings++;
        fill_cnt = 0;
        ovf_seen = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // monitor: input acceptance feeds the predictor, results are checked
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_split_result want;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            palindrome_split(i_symbol, i_is_last);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_queue.size() == 0) begin
                $display("%0t: result with none expected, outer %0d middle %0d end %0d ovf %0d",
                         $time, o_outer_len, o_middle_len, o_middle_from_end, o_overflow);
                errors++;
            end else begin
                want = result_queue.pop_front();
                if (o_outer_len !== want.outer_len) begin
                    $display("%0t: outer_len expected %0d actual %0d",
                             $time, want.outer_len, o_outer_len);
                    errors++;
                end
                if (o_middle_len !== want.middle_len) begin
                    $display("%0t: middle_len expected %0d actual %0d",
                             $time, want.middle_len, o_middle_len);
                    errors++;
                end
                if (o_middle_from_end !== want.from_end) begin
                    $display("%0t: middle_from_end expected %0d actual %0d",
                             $time, want.from_end, o_middle_from_end);
                    errors++;
                end
                if (o_overflow !== want.overflow) begin
                    $display("%0t: overflow expected %0d actual %0d",
                             $time, want.overflow, o_overflow);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: byte requests from byte_queue, changed on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_byte_req req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            // request still waiting: hold valid and payload
        end else if (in_gap > 0) begin
            in_gap--;
            i_in_valid <= 1'b0;
        end else if (byte_queue.size() > 0 &&
                     !(byte_queue[0].hold_off && result_queue.size() > 0)) begin
            // idle bursts, none near the end of the run
            if (byte_queue.size() > 200 && $urandom_range(0, 3) == 0) begin
                in_gap = $urandom_range(0, 2);
                i_in_valid <= 1'b0;
            end else begin
                req = byte_queue.pop_front();
                i_in_valid <= 1'b1;
                i_symbol   <= req.sym;
                i_is_last  <= req.last;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result side back-pressure in the same burst pattern
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else if (byte_queue.size() > 200 && $urandom_range(0, 3) == 0) begin
            out_gap = $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // string construction
    // ------------------------------------------------------------------

    // alpha 0 gives any byte, otherwise one of the first alpha letters
    function automatic logic [7:0] pick_sym(int alpha);
        if (alpha == 0) return 8'($urandom);
        return alpha_syms[$urandom_range(0, alpha - 1)];
    endfunction

    task automatic append_random(int cnt, int alpha);
        for (int i = 0; i < cnt; i++) word_q.push_back(pick_sym(alpha));
    endtask

    task automatic append_palin(int cnt, int alpha);
        logic [7:0] half[$];
        for (int i = 0; i < cnt / 2; i++) half.push_back(pick_sym(alpha));
        foreach (half[i]) word_q.push_back(half[i]);
        if (cnt % 2) word_q.push_back(pick_sym(alpha));
        for (int i = half.size() - 1; i >= 0; i--) word_q.push_back(half[i]);
    endtask

    // queue word_q as one string of byte requests
    task automatic push_string(bit hold_off);
        t_byte_req req;
        foreach (word_q[i]) begin
            req.sym      = word_q[i];
            req.last     = (i == word_q.size() - 1);
            req.hold_off = hold_off && (i == 0);
            byte_queue.push_back(req);
        end
    endtask

    // mostly structured strings over small alphabets so that mirrored ends,
    // palindromic prefixes and suffixes and ties all turn up often
    task automatic build_string();
        logic [7:0] arm[$];
        int kind, alpha, arm_len;
        word_q.delete();
        for (int i = 0; i < 3; i++) alpha_syms[i] = 8'($urandom);
        alpha   = $urandom_range(0, 3);
        kind    = $urandom_range(0, 5);
        arm_len = (kind >= 2) ? $urandom_range(0, 4) : 0;
        for (int i = 0; i < arm_len; i++) arm.push_back(pick_sym(alpha));
        foreach (arm[i]) word_q.push_back(arm[i]);
        case (kind)
            0: append_random($urandom_range(1, 12), alpha);
            1: append_random($urandom_range(13, 40), alpha);
            2: begin
                append_palin($urandom_range(1, 8), alpha);
                append_random($urandom_range(0, 5), alpha);
            end
            3: begin
                append_random($urandom_range(0, 5), alpha);
                append_palin($urandom_range(1, 8), alpha);
            end
            4: append_palin($urandom_range(0, 10), alpha);
            default: begin
                append_palin($urandom_range(1, 4), alpha);
                append_palin($urandom_range(1, 4), alpha);
            end
        endcase
        for (int i = arm.size() - 1; i >= 0; i--) word_q.push_back(arm[i]);
        if (word_q.size() == 0) word_q.push_back(pick_sym(alpha));
    endtask

    // one palindromic string a byte longer than the buffer, so the stored
    // part would give a full result if the overrun went unnoticed
    task automatic push_long_string();
        alpha_syms[0] = 8'h5A;
        alpha_syms[1] = 8'hA5;
        word_q.delete();
        append_palin(MAX_LEN + 1, 2);
        push_string(1'b1);
    endtask

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // directed: single extreme bytes, a tie, empty middle, suffix and
        // prefix picks, outer ends around a middle, odd palindrome
        word_q = '{8'h00};                               push_string(1'b0);
        word_q = '{8'hFF};                               push_string(1'b0);
        word_q = '{8'h00, 8'hFF};                        push_string(1'b0);
        word_q = '{8'h41, 8'h41};                        push_string(1'b0);
        word_q = '{8'h61, 8'h62, 8'h62};                 push_string(1'b0);
        word_q = '{8'h61, 8'h61, 8'h62};                 push_string(1'b0);
        word_q = '{8'h78, 8'h61, 8'h62, 8'h61, 8'h63, 8'h78};
        push_string(1'b0);
        word_q = '{8'h01, 8'h80, 8'h7F, 8'h80, 8'h01};   push_string(1'b0);

        // random part; the first string waits for the directed results
        while (small_items < 760) begin
            build_string();
            small_items += word_q.size();
            push_string(n_strings == 0 && byte_queue.size() < 30 ||
                        $urandom_range(0, 40) == 0);
            if (small_items >= 380 && small_items - word_q.size() < 380)
                push_long_string();
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (byte_queue.size() == 0 && !i_in_valid);
        wait (result_queue.size() == 0);
        repeat (64) @(posedge i_clk);

        $display("covered %0d strings, %0d bytes, longest %0d, %0d overflowed",
                 n_strings, n_bytes, longest, n_ovf);
        $display("%0d results took the palindrome from the middle's end", n_suffix);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog, well beyond the slowest correct run
    initial begin
        #1_600_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/psp_pkg.sv
hw/rtl/psp_dp.sv
hw/rtl/psp_ctrl.sv
hw/rtl/prefix_suffix_palindrome.sv
verif/tb_top.sv
